@@ hdl/ecj_pkg.sv @@
// Shared types, constants and helper functions for the edit cost block.
package ecj_pkg;

    localparam int MAX_REF_LEN_DEF = 256;
    localparam int FRAC_BITS       = 4;
    localparam int COST_W          = 24;
    localparam int JP_W            = 12;
    localparam int SYM_W           = 8;
    localparam int APB_ADDR_W      = 2;
    localparam int APB_DATA_W      = 32;

    typedef logic [COST_W-1:0] cost_t;
    typedef logic [JP_W-1:0]   jp_t;

    localparam cost_t ONE_UNIT   = cost_t'(1 << FRAC_BITS);
    localparam jp_t   JP_RESET   = jp_t'(16);

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_COMPARE = 2'd2,
        ACT_REPORT  = 2'd3
    } action_t;

    typedef struct packed {
        action_t          action;
        logic [SYM_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        cost_t cost;
        logic  dropped;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic cmp_start;
        logic issue;
        logic finish;
        logic rpt_issue;
        logic rpt_load;
    } cmd_t;

    typedef struct packed {
        logic issue_last;
        logic out_free;
    } status_t;

    function automatic cost_t sat_add(input cost_t a, input cost_t b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

    function automatic cost_t min_cost(input cost_t a, input cost_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ hdl/ecj_ctrl.sv @@
// Sequencer for clear, load, compare sweep and report.
module ecj_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  ecj_pkg::action_t  action,
    output logic              s_ready,
    input  ecj_pkg::status_t  status,
    output ecj_pkg::cmd_t     cmd
);
    import ecj_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (action == ACT_COMPARE) begin
                        state_next = ST_ISSUE;
                    end else if (action == ACT_REPORT) begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_ISSUE: begin
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            ST_REPORT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (action)
                        ACT_CLEAR:   cmd.clear     = 1'b1;
                        ACT_LOAD:    cmd.load      = 1'b1;
                        ACT_COMPARE: cmd.cmp_start = 1'b1;
                        ACT_REPORT:  cmd.rpt_issue = 1'b1;
                        default:     cmd           = '0;
                    endcase
                end
            end
            ST_ISSUE:  cmd.issue    = 1'b1;
            ST_DRAIN:  cmd          = '0;
            ST_FINISH: cmd.finish   = 1'b1;
            ST_REPORT: cmd.rpt_load = status.out_free;
            default:   cmd          = '0;
        endcase
    end

endmodule

@@ hdl/ecj_dpath.sv @@
// Reference and cost row memories, cell update datapath and result register.
module ecj_dpath #(
    parameter int MAX_REF_LEN = ecj_pkg::MAX_REF_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ecj_pkg::cmd_t      cmd,
    output ecj_pkg::status_t   status,
    input  ecj_pkg::in_item_t  s_data,
    input  ecj_pkg::jp_t       jump_penalty,
    output logic               m_valid,
    input  logic               m_ready,
    output ecj_pkg::out_item_t m_data
);
    import ecj_pkg::*;

    localparam int CW  = $clog2(MAX_REF_LEN + 1);
    localparam int RAW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;

    logic [SYM_W-1:0] ref_mem [MAX_REF_LEN];
    cost_t            row_mem [MAX_REF_LEN + 1];

    logic [CW-1:0]    len_reg;
    logic             started_reg;
    logic             dropped_reg;
    logic [CW-1:0]    issue_cnt_reg;
    logic [CW-1:0]    proc_cnt_reg;
    logic             pend_reg;
    logic [SYM_W-1:0] target_reg;
    logic [SYM_W-1:0] ref_q_reg;
    cost_t            row_q_reg;
    cost_t            diag_reg;
    cost_t            left_reg;
    cost_t            best_reg;
    cost_t            bound_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    // j * one never exceeds the cost range for any supported depth
    function automatic cost_t init_cell(input logic [CW-1:0] j, input jp_t jp);
        logic [CW+FRAC_BITS-1:0] sh;
        sh = (CW + FRAC_BITS)'(j) << FRAC_BITS;
        return min_cost(cost_t'(jp), cost_t'(sh));
    endfunction

    logic [CW-1:0]  row_rd_addr;
    logic [CW-1:0]  ref_rd_cnt;
    logic           row_rd_en;
    cost_t          above_eff;
    cost_t          up_cost;
    cost_t          sub_cost;
    cost_t          left_cost;
    cost_t          cell_new;
    cost_t          report_cost;

    assign row_rd_en   = cmd.issue | cmd.rpt_issue;
    assign row_rd_addr = cmd.issue ? issue_cnt_reg : len_reg;
    assign ref_rd_cnt  = issue_cnt_reg - CW'(1);

    // Clipping is deferred: the stored row holds unclipped cells and the
    // pending bound is applied when a cell is read back.
    always_comb begin
        above_eff = started_reg ? min_cost(row_q_reg, bound_reg)
                                : init_cell(proc_cnt_reg, jump_penalty);
        up_cost   = sat_add(above_eff, ONE_UNIT);
        sub_cost  = sat_add(diag_reg, (ref_q_reg == target_reg) ? '0 : ONE_UNIT);
        left_cost = sat_add(left_reg, ONE_UNIT);
        if (proc_cnt_reg == '0) begin
            cell_new = up_cost;
        end else begin
            cell_new = min_cost(min_cost(up_cost, sub_cost), left_cost);
        end
        report_cost = started_reg ? min_cost(row_q_reg, bound_reg)
                                  : init_cell(len_reg, jump_penalty);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && !started_reg && (len_reg != CW'(MAX_REF_LEN))) begin
            ref_mem[len_reg[RAW-1:0]] <= s_data.symbol;
        end
        if (cmd.issue) begin
            ref_q_reg <= ref_mem[ref_rd_cnt[RAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            row_mem[proc_cnt_reg] <= cell_new;
        end
        if (row_rd_en) begin
            row_q_reg <= row_mem[row_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            started_reg <= 1'b0;
            dropped_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.issue;
            if (cmd.clear) begin
                len_reg     <= '0;
                started_reg <= 1'b0;
                dropped_reg <= 1'b0;
            end
            if (cmd.load) begin
                if (started_reg || (len_reg == CW'(MAX_REF_LEN))) begin
                    dropped_reg <= 1'b1;
                end else begin
                    len_reg <= len_reg + CW'(1);
                end
            end
            if (cmd.finish) begin
                started_reg <= 1'b1;
            end
            if (cmd.rpt_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cmp_start) begin
            issue_cnt_reg <= '0;
            proc_cnt_reg  <= '0;
            target_reg    <= s_data.symbol;
        end
        if (cmd.issue) begin
            issue_cnt_reg <= issue_cnt_reg + CW'(1);
        end
        if (pend_reg) begin
            proc_cnt_reg <= proc_cnt_reg + CW'(1);
            diag_reg     <= above_eff;
            left_reg     <= cell_new;
            best_reg     <= (proc_cnt_reg == '0) ? cell_new : min_cost(best_reg, cell_new);
        end
        if (cmd.finish) begin
            bound_reg <= sat_add(best_reg, cost_t'(jump_penalty));
        end
        if (cmd.rpt_load) begin
            m_data_reg.cost    <= report_cost;
            m_data_reg.dropped <= dropped_reg;
        end
    end

    assign status.issue_last = (issue_cnt_reg == len_reg);
    assign status.out_free   = !m_valid_reg || m_ready;
    assign m_valid           = m_valid_reg;
    assign m_data            = m_data_reg;

endmodule

@@ hdl/edit_cost_with_jumps.sv @@
// Top level: edit cost with jump penalty, APB register and stream channels.
//
// Reference bytes are loaded one per transfer, then each target byte runs a
// single sweep over the stored cost row, one cell per cycle through the row
// memory's read and write ports. A report waits for the result register to
// drain before it loads. The row minimum is gathered during the sweep and the
// jump clip is applied as cells are read back, so no second pass is needed.
// The row needs no clearing after reset; the first compare builds it.
module edit_cost_with_jumps #(
    parameter int MAX_REF_LEN = ecj_pkg::MAX_REF_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ecj_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ecj_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ecj_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ecj_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ecj_pkg::out_item_t                m_data
);
    import ecj_pkg::*;

    jp_t     jump_penalty_reg;
    cmd_t    cmd;
    status_t status;
    logic    cfg_write;

    // single register: every byte offset decodes to it
    assign cfg_write = psel && penable && pwrite && (paddr <= APB_ADDR_W'(3));
    assign pready    = 1'b1;
    assign prdata    = APB_DATA_W'(jump_penalty_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jump_penalty_reg <= JP_RESET;
        end else if (cfg_write) begin
            jump_penalty_reg <= pwdata[JP_W-1:0];
        end
    end

    ecj_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .action  (s_data.action),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ecj_dpath #(
        .MAX_REF_LEN (MAX_REF_LEN)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_data       (s_data),
        .jump_penalty (jump_penalty_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

@@ verif/tb_top.sv @@
// Testbench for edit_cost_with_jumps: cost row predictor, report scoreboard, stream and APB drivers.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ecj_pkg::*;

    localparam int REF_CAP       = MAX_REF_LEN_DEF;
    localparam int ITEM_TARGET   = 1000;
    localparam int PHASE_COUNT   = 6;
    localparam int SETTLE_CYCLES = 320;  // full-length sweep plus slack
    localparam logic [APB_ADDR_W-1:0] JUMP_PENALTY_ADDR = '0;

    // Tracks reference store and cost row, queues the expected reports.
    class edit_cost_tracker;
        jp_t        penalty;
        logic [7:0] ref_bytes [REF_CAP];
        cost_t      row [REF_CAP+1];
        int         ref_len;
        bit         started;
        bit         lost_load;
        out_item_t  expected_reports [$];
        int         errors;

        function new();
            penalty   = JP_RESET;
            ref_len   = 0;
            started   = 0;
            lost_load = 0;
            errors    = 0;
            foreach (ref_bytes[i]) ref_bytes[i] = '0;
            foreach (row[i]) row[i] = '0;
        endfunction

        function cost_t capped_sum(cost_t a, cost_t b);
            logic [COST_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
        endfunction

        function cost_t lesser(cost_t a, cost_t b);
            return (a < b) ? a : b;
        endfunction

        // Row value before the first target byte: min(penalty, j units).
        function cost_t start_cell(int j);
            return lesser(cost_t'(penalty), capped_sum('0, cost_t'(j) << FRAC_BITS));
        endfunction

        function void sweep_row(logic [7:0] sym);
            cost_t diag, above, sub, v, best, bound;
            int j;
            if (!started) begin
                for (j = 0; j <= ref_len; j++) row[j] = start_cell(j);
                started = 1;
            end
            diag   = row[0];
            row[0] = capped_sum(row[0], ONE_UNIT);
            for (j = 1; j <= ref_len; j++) begin
                above = row[j];
                sub   = capped_sum(diag, (sym == ref_bytes[j-1]) ? cost_t'(0) : ONE_UNIT);
                v     = lesser(lesser(capped_sum(above, ONE_UNIT), sub),
                               capped_sum(row[j-1], ONE_UNIT));
                diag   = above;
                row[j] = v;
            end
            best = row[0];
            for (j = 1; j <= ref_len; j++) best = lesser(best, row[j]);
            bound = capped_sum(best, cost_t'(penalty));
            for (j = 0; j <= ref_len; j++)
                if (row[j] > bound) row[j] = bound;
        endfunction

        function void take_item(in_item_t it);
            out_item_t rpt;
            case (it.action)
                ACT_CLEAR: begin
                    ref_len   = 0;
                    started   = 0;
                    lost_load = 0;
                end
                ACT_LOAD: begin
                    if (started || ref_len >= REF_CAP) begin
                        lost_load = 1;
                    end else begin
                        ref_bytes[ref_len] = it.symbol;
                        ref_len++;
                    end
                end
                ACT_COMPARE: sweep_row(it.symbol);
                default: begin
                    rpt.cost    = started ? row[ref_len] : start_cell(ref_len);
                    rpt.dropped = lost_load;
                    expected_reports.push_back(rpt);
                end
            endcase
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t: report with none pending: cost=%0d dropped=%0b",
                         $time, got.cost, got.dropped);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.cost !== want.cost) begin
                $display("%0t: cost mismatch: expected %0d, actual %0d",
                         $time, want.cost, got.cost);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $display("%0t: dropped mismatch: expected %0b, actual %0b",
                         $time, want.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    edit_cost_tracker tracker;
    int               items_sent;

    edit_cost_with_jumps #(.MAX_REF_LEN(REF_CAP)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Mostly zero or short, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Narrow alphabet gives frequent matches against the reference.
    function automatic logic [7:0] pick_symbol(bit narrow);
        if (narrow) return 8'h60 + 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready) tracker.take_item(s_data);
            if (m_valid && m_ready) tracker.check_report(m_data);
        end
    end

    initial begin : result_sink
        int n;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Valid stays up across back-to-back transfers; dropped only before a gap.
    task automatic send_item(input action_t act, input logic [7:0] sym);
        in_item_t it;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.action = act;
        it.symbol = sym;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Setup then access; psel is left high so accesses can follow back to back.
    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= JUMP_PENALTY_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic check_penalty_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[JP_W-1:0] !== tracker.penalty) begin
            $display("%0t: jump_penalty readback: expected %0d, actual %0d",
                     $time, tracker.penalty, rd[JP_W-1:0]);
            tracker.errors++;
        end
    endtask

    // Wait out pending reports, then a full sweep so a trailing compare is done.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_penalty(input jp_t value);
        logic [APB_DATA_W-1:0] rd;
        drain_block();
        apb_access(1'b1, APB_DATA_W'(value), rd);
        tracker.penalty = value;
        check_penalty_readback();
    endtask

    // Clear, load a reference, then mostly compares with reports mixed in.
    task automatic run_sequence(input bit fill);
        int len, ncmp, k, r;
        bit narrow;
        r = $urandom_range(0, 99);
        if (fill) len = REF_CAP + 2;
        else if (r < 2) len = $urandom_range(REF_CAP - 2, REF_CAP + 6);
        else if (r < 10) len = 0;
        else len = $urandom_range(1, 12);
        narrow = 1'($urandom_range(0, 1));
        send_item(ACT_CLEAR, pick_symbol(0));
        for (k = 0; k < len; k++) begin
            send_item(ACT_LOAD, pick_symbol(narrow));
            if ($urandom_range(0, 15) == 0) send_item(ACT_REPORT, pick_symbol(0));
        end
        ncmp = (len > 200) ? $urandom_range(2, 6) : $urandom_range(0, 14);
        for (k = 0; k < ncmp; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_item(ACT_COMPARE, pick_symbol(narrow));
            else if (r < 90) send_item(ACT_REPORT, pick_symbol(0));
            else if (r < 95) send_item(ACT_LOAD, pick_symbol(narrow));
            else send_item(action_t'($urandom_range(0, 3)), pick_symbol(0));
        end
        send_item(ACT_REPORT, pick_symbol(0));
    endtask

    initial begin : stimulus
        int p, goal;
        jp_t pen;
        tracker    = new();
        items_sent = 0;
        aresetn <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        check_penalty_readback();

        // empty reference, before and after a compare
        send_item(ACT_REPORT, 8'h00);
        send_item(ACT_COMPARE, 8'h00);
        send_item(ACT_REPORT, 8'hFF);
        send_item(ACT_CLEAR, 8'hFF);
        send_item(ACT_LOAD, 8'h00);
        send_item(ACT_LOAD, 8'hFF);
        send_item(ACT_LOAD, 8'hA5);
        send_item(ACT_LOAD, 8'h5A);
        send_item(ACT_REPORT, 8'h00);   // before any compare
        send_item(ACT_COMPARE, 8'h00);
        send_item(ACT_COMPARE, 8'hFF);
        send_item(ACT_COMPARE, 8'h11);
        send_item(ACT_REPORT, 8'h00);
        send_item(ACT_LOAD, 8'h33);     // late load, dropped
        send_item(ACT_REPORT, 8'hFF);
        send_item(ACT_CLEAR, 8'h00);
        send_item(ACT_REPORT, 8'h00);
        send_item(ACT_LOAD, 8'hFF);
        send_item(ACT_COMPARE, 8'hFF);
        send_item(ACT_REPORT, 8'h00);
        send_item(ACT_COMPARE, 8'h00);
        send_item(ACT_REPORT, 8'hFF);

        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       pen = jp_t'(0);
                1:       pen = {JP_W{1'b1}};
                2:       pen = jp_t'($urandom_range(1, 40));
                3:       pen = jp_t'(1);
                4:       pen = jp_t'($urandom_range(0, 4095));
                default: pen = jp_t'($urandom_range(8, 200));
            endcase
            set_penalty(pen);
            goal = items_sent + ITEM_TARGET / PHASE_COUNT;
            run_sequence(p == 2);
            while (items_sent < goal) run_sequence(0);
        end

        drain_block();
        if (tracker.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
